// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked after reset is released
`define HDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define HDR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/hdr_pkg.sv =====
package hdr_pkg;

  localparam int CELLS   = 64;
  localparam int CELLS_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W   = $clog2(CELLS + 1);

  localparam int HEAT_W  = 24;
  localparam int FLASH_W = 17;
  localparam int IDX_W   = 16;
  localparam int CMD_W   = 2;
  localparam int STEP_W  = 5;
  localparam int REG_W   = 2;
  localparam int DATA_W  = 17;
  localparam int MUL_W   = 41;

  localparam logic [HEAT_W-1:0]  HEAT_RESET = 24'd4669440;
  localparam logic [FLASH_W-1:0] ONE_Q16    = 17'h10000;

  localparam logic [CMD_W-1:0] CMD_APPLY  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam logic [REG_W-1:0] REG_APPLY_RETAIN   = 2'd0;
  localparam logic [REG_W-1:0] REG_DIFFUSE_SPREAD = 2'd1;
  localparam logic [REG_W-1:0] REG_SUBSTEP_COUNT  = 2'd2;
  localparam logic [REG_W-1:0] REG_FLASH_DECAY    = 2'd3;

  typedef struct packed {
    logic             idle;
    logic             load_item;
    logic             use_item;
    logic             clear;
    logic             ap_m1;
    logic             ap_m2;
    logic             ap_wr;
    logic             cp_wr;
    logic             df_init;
    logic             df_mul;
    logic             df_wr;
    logic             fl_mul;
    logic             fl_wr;
    logic             sm_out;
    logic [CNT_W-1:0] cnt;
  } hdr_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic              apply_ok;
    logic [STEP_W-1:0] steps;
    logic              out_free;
  } hdr_status_t;

endpackage

// ===== rtl/hdr_if.sv =====
interface hdr_item_if;
  logic                          valid;
  logic                          ready;
  logic [hdr_pkg::CMD_W-1:0]     command;
  logic signed [hdr_pkg::IDX_W-1:0] cell_index;
  logic [hdr_pkg::HEAT_W-1:0]    heat_target;
  modport source (output valid, command, cell_index, heat_target, input ready);
  modport sink (input valid, command, cell_index, heat_target, output ready);
endinterface

interface hdr_result_if;
  logic                        valid;
  logic                        ready;
  logic [hdr_pkg::HEAT_W-1:0]  heat_value;
  logic [hdr_pkg::FLASH_W-1:0] flash_level;
  modport source (output valid, heat_value, flash_level, input ready);
  modport sink (input valid, heat_value, flash_level, output ready);
endinterface

interface hdr_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [hdr_pkg::REG_W-1:0]  index;
  logic [hdr_pkg::DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/hdr_ctrl.sv =====
module hdr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  hdr_pkg::hdr_status_t status,
  output hdr_pkg::hdr_cmd_t    cmd
);
  import hdr_pkg::*;

  typedef enum logic [16:0] {
    ST_CLEAR  = 17'b00000000000000001,
    ST_IDLE   = 17'b00000000000000010,
    ST_DECODE = 17'b00000000000000100,
    ST_AP_RD  = 17'b00000000000001000,
    ST_AP_M1  = 17'b00000000000010000,
    ST_AP_M2  = 17'b00000000000100000,
    ST_AP_WR  = 17'b00000000001000000,
    ST_CP_RD  = 17'b00000000010000000,
    ST_CP_WR  = 17'b00000000100000000,
    ST_DF_RD  = 17'b00000001000000000,
    ST_DF_MUL = 17'b00000010000000000,
    ST_DF_WR  = 17'b00000100000000000,
    ST_FL_RD  = 17'b00001000000000000,
    ST_FL_MUL = 17'b00010000000000000,
    ST_FL_WR  = 17'b00100000000000000,
    ST_SM_RD  = 17'b01000000000000000,
    ST_SM_OUT = 17'b10000000000000000
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [STEP_W-1:0] sub, sub_next;
  logic              cnt_last;
  logic              cnt_end;

  assign cnt_last = (cnt == CNT_W'(CELLS - 1));
  assign cnt_end  = (cnt == CNT_W'(CELLS));

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sub_next   = sub;
    cmd        = '0;
    cmd.cnt    = cnt;
    case (state)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        cnt_next  = cnt + 1'b1;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd.idle      = 1'b1;
        cmd.load_item = item_valid;
        if (item_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cnt_next = '0;
        case (status.command)
          CMD_APPLY:  state_next = status.apply_ok ? ST_AP_RD : ST_IDLE;
          CMD_TICK:   state_next = ST_CP_RD;
          CMD_SAMPLE: state_next = ST_SM_RD;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_AP_RD: begin
        cmd.use_item = 1'b1;
        state_next   = ST_AP_M1;
      end
      ST_AP_M1: begin
        cmd.ap_m1  = 1'b1;
        state_next = ST_AP_M2;
      end
      ST_AP_M2: begin
        cmd.ap_m2  = 1'b1;
        state_next = ST_AP_WR;
      end
      ST_AP_WR: begin
        cmd.use_item = 1'b1;
        cmd.ap_wr    = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_CP_RD: begin
        state_next = ST_CP_WR;
      end
      ST_CP_WR: begin
        cmd.cp_wr = 1'b1;
        cnt_next  = cnt + 1'b1;
        state_next = ST_CP_RD;
        if (cnt_last) begin
          cmd.df_init = 1'b1;
          cnt_next    = '0;
          sub_next    = '0;
          state_next  = ST_DF_RD;
        end
      end
      ST_DF_RD: begin
        state_next = ST_DF_MUL;
      end
      ST_DF_MUL: begin
        cmd.df_mul = 1'b1;
        state_next = ST_DF_WR;
      end
      ST_DF_WR: begin
        cmd.df_wr  = 1'b1;
        cnt_next   = cnt + 1'b1;
        state_next = ST_DF_RD;
        if (cnt_end) begin
          cnt_next = '0;
          if (sub + 1'b1 == status.steps) begin
            state_next = ST_FL_RD;
          end else begin
            sub_next    = sub + 1'b1;
            cmd.df_init = 1'b1;
          end
        end
      end
      ST_FL_RD: begin
        state_next = ST_FL_MUL;
      end
      ST_FL_MUL: begin
        cmd.fl_mul = 1'b1;
        state_next = ST_FL_WR;
      end
      ST_FL_WR: begin
        cmd.fl_wr  = 1'b1;
        cnt_next   = cnt + 1'b1;
        state_next = ST_FL_RD;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_SM_RD: begin
        cmd.use_item = 1'b1;
        state_next   = ST_SM_OUT;
      end
      ST_SM_OUT: begin
        cmd.use_item = 1'b1;
        cmd.sm_out   = 1'b1;
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      sub   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sub   <= sub_next;
    end
  end

endmodule

// ===== rtl/hdr_dpath.sv =====
module hdr_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  hdr_pkg::hdr_cmd_t                  cmd,
  output hdr_pkg::hdr_status_t               status,
  input  logic [hdr_pkg::CMD_W-1:0]          item_command,
  input  logic signed [hdr_pkg::IDX_W-1:0]   item_index,
  input  logic [hdr_pkg::HEAT_W-1:0]         item_target,
  input  logic                               cfg_valid,
  input  logic [hdr_pkg::REG_W-1:0]          cfg_index,
  input  logic [hdr_pkg::DATA_W-1:0]         cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [hdr_pkg::HEAT_W-1:0]         out_heat,
  output logic [hdr_pkg::FLASH_W-1:0]        out_flash
);
  import hdr_pkg::*;

  localparam logic signed [HEAT_W+2:0] SUM_MAX = (HEAT_W+3)'(24'hFFFFFF);

  logic [16:0]        apply_retain;
  logic [15:0]        diffuse_spread;
  logic [STEP_W-1:0]  substep_count;
  logic [16:0]        flash_decay;
  logic [16:0]        retain_eff;
  logic [16:0]        decay_eff;

  logic [CMD_W-1:0]         cmd_q;
  logic signed [IDX_W-1:0]  idx_q;
  logic [HEAT_W-1:0]        target_q;
  logic [CELLS_W-1:0]       item_addr;

  logic [HEAT_W-1:0]  heat_mem  [CELLS];
  logic [HEAT_W-1:0]  last_mem  [CELLS];
  logic [FLASH_W-1:0] flash_mem [CELLS];
  logic [HEAT_W-1:0]  heat_rd;
  logic [HEAT_W-1:0]  last_rd;
  logic [FLASH_W-1:0] flash_rd;
  logic [CELLS_W-1:0] rd_addr;
  logic [CNT_W-1:0]   cnt_m1;

  logic               heat_we;
  logic [CELLS_W-1:0] heat_wa;
  logic [HEAT_W-1:0]  heat_wd;
  logic               last_we;
  logic [HEAT_W-1:0]  last_wd;
  logic               flash_we;
  logic [FLASH_W-1:0] flash_wd;

  logic [HEAT_W-1:0]  mul_a;
  logic [16:0]        mul_b;
  logic [MUL_W-1:0]   mul_q;
  logic [MUL_W-1:0]   acc_q;
  logic [MUL_W:0]     ap_sum;

  logic [HEAT_W-1:0]        cur_h, nxt_h, cur_v, prev_v, nxt_v;
  logic                     has_left, has_right;
  logic signed [HEAT_W+2:0] df_sum;
  logic [HEAT_W-1:0]        df_sat;
  logic                     chg;
  logic                     out_free;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      apply_retain   <= 17'd65148;
      diffuse_spread <= 16'd10178;
      substep_count  <= 5'd10;
      flash_decay    <= 17'd64783;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_APPLY_RETAIN:   apply_retain   <= cfg_data;
        REG_DIFFUSE_SPREAD: diffuse_spread <= cfg_data[15:0];
        REG_SUBSTEP_COUNT:  substep_count  <= cfg_data[STEP_W-1:0];
        REG_FLASH_DECAY:    flash_decay    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign retain_eff = (apply_retain > ONE_Q16) ? ONE_Q16 : apply_retain;
  assign decay_eff  = (flash_decay > ONE_Q16) ? ONE_Q16 : flash_decay;

  always_comb begin
    if (substep_count == '0) status.steps = STEP_W'(1);
    else if (substep_count > STEP_W'(16)) status.steps = STEP_W'(16);
    else status.steps = substep_count;
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_q    <= item_command;
      idx_q    <= item_index;
      target_q <= item_target;
    end
  end

  always_comb begin
    if (idx_q[IDX_W-1]) item_addr = '0;
    else if (idx_q > IDX_W'(CELLS - 1)) item_addr = CELLS_W'(CELLS - 1);
    else item_addr = idx_q[CELLS_W-1:0];
  end

  assign status.command  = cmd_q;
  assign status.apply_ok = !idx_q[IDX_W-1] && (idx_q < IDX_W'(CELLS));
  assign out_free        = !out_valid || out_ready;
  assign status.out_free = out_free;

  // memories
  assign cnt_m1  = cmd.cnt - 1'b1;
  assign rd_addr = cmd.use_item ? item_addr : cmd.cnt[CELLS_W-1:0];

  always_comb begin
    heat_we = 1'b0;
    heat_wa = cmd.cnt[CELLS_W-1:0];
    heat_wd = HEAT_RESET;
    if (cmd.clear) begin
      heat_we = 1'b1;
    end else if (cmd.ap_wr) begin
      heat_we = 1'b1;
      heat_wa = item_addr;
      heat_wd = ap_sum[HEAT_W+15:16];
    end else if (cmd.df_wr && cmd.cnt != '0) begin
      heat_we = 1'b1;
      heat_wa = cnt_m1[CELLS_W-1:0];
      heat_wd = df_sat;
    end
  end

  assign last_we  = cmd.clear || cmd.cp_wr;
  assign last_wd  = cmd.clear ? HEAT_RESET : heat_rd;
  assign flash_we = cmd.clear || cmd.fl_wr;
  assign flash_wd = cmd.clear ? '0 : (chg ? ONE_Q16 : mul_q[FLASH_W+15:16]);

  always_ff @(posedge clk) begin
    if (heat_we) heat_mem[heat_wa] <= heat_wd;
    heat_rd <= heat_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (last_we) last_mem[cmd.cnt[CELLS_W-1:0]] <= last_wd;
    last_rd <= last_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (flash_we) flash_mem[cmd.cnt[CELLS_W-1:0]] <= flash_wd;
    flash_rd <= flash_mem[rd_addr];
  end

  // shared multiplier
  always_comb begin
    mul_a = heat_rd;
    mul_b = {1'b0, diffuse_spread};
    if (cmd.ap_m1) begin
      mul_b = retain_eff;
    end else if (cmd.ap_m2) begin
      mul_a = target_q;
      mul_b = ONE_Q16 - retain_eff;
    end else if (cmd.fl_mul) begin
      mul_a = HEAT_W'(flash_rd);
      mul_b = decay_eff;
    end
  end

  always_ff @(posedge clk) begin
    mul_q <= MUL_W'(mul_a) * MUL_W'(mul_b);
    if (cmd.ap_m2) acc_q <= mul_q;
    if (cmd.fl_mul) chg <= (heat_rd[HEAT_W-1:14] != last_rd[HEAT_W-1:14]);
  end

  assign ap_sum = (MUL_W+1)'(acc_q) + (MUL_W+1)'(mul_q);

  // diffusion window
  assign has_left  = cmd.cnt > CNT_W'(1);
  assign has_right = cmd.cnt < CNT_W'(CELLS);
  assign nxt_v     = has_right ? mul_q[HEAT_W+15:16] : '0;

  always_comb begin
    df_sum = $signed({3'b000, cur_h}) + $signed({3'b000, prev_v})
           + $signed({3'b000, nxt_v});
    if (has_left) df_sum = df_sum - $signed({3'b000, cur_v});
    if (has_right) df_sum = df_sum - $signed({3'b000, cur_v});
    if (df_sum < 0) df_sat = '0;
    else if (df_sum > SUM_MAX) df_sat = {HEAT_W{1'b1}};
    else df_sat = df_sum[HEAT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.df_init) begin
      cur_h  <= '0;
      cur_v  <= '0;
      prev_v <= '0;
    end else if (cmd.df_wr) begin
      prev_v <= cur_v;
      cur_v  <= nxt_v;
      cur_h  <= nxt_h;
    end
    if (cmd.df_mul) nxt_h <= heat_rd;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.sm_out && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sm_out && out_free) begin
      out_heat  <= heat_rd;
      out_flash <= flash_rd;
    end
  end

endmodule

// ===== rtl/heat_diffusion_row.sv =====
// heat_diffusion_row: a row of 64 cell temperatures with flash levels
// item channel: command (apply, tick, sample), signed cell index, target
// result channel: heat and flash of a sampled cell, one beat per sample
// cfg channel: register index and data, always ready, write only when idle
// after reset a clearing pass over all cells loads 285.0 kelvin, zero flash;
//   the item channel is not ready until it ends
// one item at a time; ready again once back in idle, after:
//   apply decode, read, heat and target multiplies, write; sample
//   decode, read, output; command 3 or apply off the row decode only;
//   tick decode, copy pass, a diffusion pass per substep, flash pass
// the tick walks the cell memory once per substep, in read, multiply
//   and write states a cell, due to one read port and a shared multiplier
// a sample beat passes decode, read and output states into an output
//   register; while the receiver stalls, further apply and tick items
//   are still taken, a second sample waits until the first beat is taken
module heat_diffusion_row (
  input  logic clk,
  input  logic rst,
  hdr_item_if.sink     item,
  hdr_result_if.source result,
  hdr_cfg_if.sink      cfg
);
  import hdr_pkg::*;

  hdr_cmd_t    cmd;
  hdr_status_t status;

  hdr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .status     (status),
    .cmd        (cmd)
  );

  hdr_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item_command (item.command),
    .item_index   (item.cell_index),
    .item_target  (item.heat_target),
    .cfg_valid    (cfg.valid),
    .cfg_index    (cfg.index),
    .cfg_data     (cfg.data),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_heat     (result.heat_value),
    .out_flash    (result.flash_level)
  );

  assign item.ready = cmd.idle;
  assign cfg.ready  = 1'b1;

`include "assert_macros.svh"

  `HDR_ASSERT(a_accept_leaves_idle, (item.valid && item.ready) |=> !item.ready, "busy after accept")
  `HDR_ASSERT(a_result_from_sample, $rose(result.valid) |-> $past(cmd.sm_out), "stray result")
  `HDR_ASSERT(a_steps_range, (status.steps != '0) && (status.steps <= 5'd16), "bad steps")

endmodule

// ===== bench/heat_diffusion_row_tb.sv =====
`timescale 1ns / 1ps

class heat_row_scoreboard;
  logic [hdr_pkg::HEAT_W-1:0]  heat  [hdr_pkg::CELLS];
  logic [hdr_pkg::HEAT_W-1:0]  last  [hdr_pkg::CELLS];
  logic [hdr_pkg::FLASH_W-1:0] flash [hdr_pkg::CELLS];
  logic [16:0] retain;
  logic [15:0] spread;
  logic [4:0]  steps;
  logic [16:0] decay;
  logic [hdr_pkg::HEAT_W-1:0]  heat_q[$];
  logic [hdr_pkg::FLASH_W-1:0] flash_q[$];
  int errors;

  function new();
    for (int i = 0; i < hdr_pkg::CELLS; i++) begin
      heat[i] = hdr_pkg::HEAT_RESET;
      last[i] = hdr_pkg::HEAT_RESET;
      flash[i] = '0;
    end
    retain = 17'd65148;
    spread = 16'd10178;
    steps = 5'd10;
    decay = 17'd64783;
    errors = 0;
  endfunction

  function void write_reg(logic [hdr_pkg::REG_W-1:0] idx, logic [hdr_pkg::DATA_W-1:0] d);
    case (idx)
      hdr_pkg::REG_APPLY_RETAIN:   retain = d;
      hdr_pkg::REG_DIFFUSE_SPREAD: spread = d[15:0];
      hdr_pkg::REG_SUBSTEP_COUNT:  steps = d[4:0];
      hdr_pkg::REG_FLASH_DECAY:    decay = d;
      default: ;
    endcase
  endfunction

  function void diffuse();
    longint nxt[hdr_pkg::CELLS];
    longint v;
    for (int i = 0; i < hdr_pkg::CELLS; i++) nxt[i] = heat[i];
    for (int i = 0; i < hdr_pkg::CELLS; i++) begin
      v = (longint'(heat[i]) * spread) >>> 16;
      if (i > 0) begin
        nxt[i-1] += v;
        nxt[i] -= v;
      end
      if (i < hdr_pkg::CELLS - 1) begin
        nxt[i+1] += v;
        nxt[i] -= v;
      end
    end
    for (int i = 0; i < hdr_pkg::CELLS; i++) begin
      if (nxt[i] < 0) nxt[i] = 0;
      if (nxt[i] > 16777215) nxt[i] = 16777215;
      heat[i] = nxt[i][23:0];
    end
  endfunction

  function void note_item(logic [1:0] cmd, logic signed [15:0] idx, logic [23:0] tgt);
    longint r;
    longint d;
    int n;
    int k;
    k = idx;
    case (cmd)
      hdr_pkg::CMD_APPLY: begin
        if (k >= 0 && k < hdr_pkg::CELLS) begin
          r = (retain > 65536) ? 65536 : retain;
          heat[k] = 24'((longint'(heat[k]) * r + longint'(tgt) * (65536 - r)) >> 16);
        end
      end
      hdr_pkg::CMD_TICK: begin
        n = steps;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        d = (decay > 65536) ? 65536 : decay;
        for (int i = 0; i < hdr_pkg::CELLS; i++) last[i] = heat[i];
        for (int s = 0; s < n; s++) diffuse();
        for (int i = 0; i < hdr_pkg::CELLS; i++) begin
          flash[i] = 17'((longint'(flash[i]) * d) >> 16);
          if (last[i][23:14] != heat[i][23:14]) flash[i] = hdr_pkg::ONE_Q16;
        end
      end
      hdr_pkg::CMD_SAMPLE: begin
        if (k < 0) k = 0;
        if (k > hdr_pkg::CELLS - 1) k = hdr_pkg::CELLS - 1;
        heat_q.push_back(heat[k]);
        flash_q.push_back(flash[k]);
      end
      default: ;
    endcase
  endfunction

  function void check_sample(logic [23:0] h, logic [16:0] f);
    if (heat_q.size() == 0) begin
      errors++;
      $display("%0t: sample beat with none expected, actual heat %0d flash %0d", $time, h, f);
      return;
    end
    if (heat_q[0] !== h) begin
      errors++;
      $display("%0t: heat_value expected %0d actual %0d", $time, heat_q[0], h);
    end
    if (flash_q[0] !== f) begin
      errors++;
      $display("%0t: flash_level expected %0d actual %0d", $time, flash_q[0], f);
    end
    void'(heat_q.pop_front());
    void'(flash_q.pop_front());
  endfunction
endclass

module heat_diffusion_row_tb;
  import hdr_pkg::*;

  localparam int SETTLE = 3600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit calm = 1'b0;
  heat_row_scoreboard sb = new();

  hdr_item_if item();
  hdr_result_if result();
  hdr_cfg_if cfg();

  heat_diffusion_row dut (.clk(clk), .rst(rst), .item(item.sink), .result(result.source),
                          .cfg(cfg.sink));

  always #5 clk = ~clk;

  initial begin
    item.valid = 1'b0;
    item.command = '0;
    item.cell_index = '0;
    item.heat_target = '0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    result.ready = 1'b0;
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready)
      sb.check_sample(result.heat_value, result.flash_level);
    if (calm) begin
      result.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result.ready <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 2);
      result.ready <= 1'b0;
    end else begin
      result.ready <= 1'b1;
    end
  end

  task automatic send_item(logic [1:0] cmd, logic signed [15:0] idx, logic [23:0] tgt);
    if (!calm && $urandom_range(0, 4) == 0) begin
      item.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item.valid <= 1'b1;
    item.command <= cmd;
    item.cell_index <= idx;
    item.heat_target <= tgt;
    do @(posedge clk); while (!item.ready);
    sb.note_item(cmd, idx, tgt);
  endtask

  task automatic write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] d);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= d;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, d);
  endtask

  task automatic drain();
    item.valid <= 1'b0;
    while (sb.heat_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_regs(logic [16:0] r, logic [15:0] s, logic [4:0] n, logic [16:0] d);
    write_reg(REG_APPLY_RETAIN, r);
    write_reg(REG_DIFFUSE_SPREAD, {1'b0, s});
    write_reg(REG_SUBSTEP_COUNT, {12'd0, n});
    write_reg(REG_FLASH_DECAY, d);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_random(int count, bit hold_once);
    int pick;
    logic signed [15:0] idx;
    logic [23:0] tgt;
    logic [1:0] cmd;
    for (int i = 0; i < count; i++) begin
      if (hold_once && i == count / 3) begin
        item.valid <= 1'b0;
        do @(posedge clk); while (sb.heat_q.size() != 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 12) cmd = CMD_TICK;
      else if (pick < 50) cmd = CMD_APPLY;
      else if (pick < 97) cmd = CMD_SAMPLE;
      else cmd = CMD_UNUSED;
      idx = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, CELLS - 1));
      case ($urandom_range(0, 2))
        0: tgt = 24'($urandom);
        1: tgt = HEAT_RESET + 24'($urandom_range(0, 200000)) - 24'd100000;
        default: tgt = ($urandom_range(0, 1) == 1) ? 24'hFFFFFF : 24'd0;
      endcase
      send_item(cmd, idx, tgt);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(CMD_SAMPLE, -16'sd32768, 24'd0);
    send_item(CMD_SAMPLE, 16'sd32767, 24'hFFFFFF);
    send_item(CMD_APPLY, 16'sd0, 24'hFFFFFF);
    send_item(CMD_APPLY, 16'sd63, 24'd0);
    send_item(CMD_APPLY, -16'sd1, 24'hFFFFFF);
    send_item(CMD_APPLY, 16'sd64, 24'hFFFFFF);
    send_item(CMD_APPLY, 16'sd32767, 24'h555555);
    send_item(CMD_APPLY, -16'sd32768, 24'hAAAAAA);
    send_item(CMD_UNUSED, 16'sd5, 24'h123456);
    send_item(CMD_SAMPLE, -16'sd1, 24'd0);
    send_item(CMD_SAMPLE, 16'sd64, 24'd0);
    send_item(CMD_TICK, 16'sd0, 24'd0);
    send_item(CMD_SAMPLE, 16'sd0, 24'd0);
    send_item(CMD_SAMPLE, 16'sd1, 24'd0);
    send_item(CMD_SAMPLE, 16'sd63, 24'd0);
    send_item(CMD_SAMPLE, 16'sd62, 24'd0);
    run_random(160, 1'b1);
    drain();

    load_regs(17'd65536, 16'd32768, 5'd16, 17'd65536);
    run_random(150, 1'b0);
    drain();

    load_regs(17'd0, 16'd0, 5'd0, 17'd0);
    run_random(150, 1'b0);
    drain();

    load_regs(17'h1FFFF, 16'hFFFF, 5'd31, 17'h1FFFF);
    send_item(CMD_APPLY, 16'sd10, 24'hFFFFFF);
    send_item(CMD_TICK, 16'sd0, 24'd0);
    send_item(CMD_SAMPLE, 16'sd10, 24'd0);
    send_item(CMD_SAMPLE, 16'sd11, 24'd0);
    drain();
    load_regs(17'h1FFFF, 16'hFFFF, 5'd1, 17'h1FFFF);
    drain();
    load_regs(17'($urandom), 16'($urandom_range(30000, 65535)), 5'd1, 17'($urandom));
    run_random(120, 1'b0);
    drain();

    load_regs(17'($urandom_range(0, 65536)), 16'($urandom_range(0, 32768)),
              5'($urandom_range(1, 4)), 17'($urandom_range(0, 65536)));
    run_random(130, 1'b0);
    calm = 1'b1;
    run_random(120, 1'b0);
    item.valid <= 1'b0;

    while (sb.heat_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.heat_q.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d samples expected but not seen", $time, sb.heat_q.size());
    end
    if (sb.errors == 0) begin
      $display("heat_diffusion_row regression: pass");
    end else begin
      $display("heat_diffusion_row regression: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("heat_diffusion_row regression: fail");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/hdr_pkg.sv
rtl/hdr_if.sv
rtl/hdr_ctrl.sv
rtl/hdr_dpath.sv
rtl/heat_diffusion_row.sv
bench/heat_diffusion_row_tb.sv
